// File: src/bpcd_pkg.sv
// Package with the widths, reset values, register indexes and result type of the button dimmer.
package bpcd_pkg;

	localparam int unsigned ElapsedW = 11;
	localparam int unsigned DivW     = 8;
	localparam int unsigned DutyW    = 10;
	localparam int unsigned BlinkW   = 16;
	localparam int unsigned CfgIdxW  = 3;
	localparam int unsigned CfgDataW = 16;

	localparam logic [ElapsedW-1:0] ElapsedMax = '1;

	localparam logic [ElapsedW-1:0] LongPressRst   = 11'd1000;
	localparam logic [ElapsedW-1:0] DoublePressRst = 11'd500;
	localparam logic [ElapsedW-1:0] DebounceRst    = 11'd50;
	localparam logic [DivW-1:0]     RampDivRst     = 8'd50;
	localparam logic [DutyW-1:0]    DutyMaxRst     = 10'd1000;
	localparam logic [BlinkW-1:0]   BlinkOnRst     = 16'd50;
	localparam logic [BlinkW-1:0]   BlinkOffRst    = 16'd300;
	localparam logic [DutyW-1:0]    DutyLevelRst   = 10'd500;

	localparam logic [1:0] PressCountDouble = 2'd2;

	typedef enum logic [CfgIdxW-1:0] {
		REG_LONG_PRESS   = 3'd0,
		REG_DOUBLE_PRESS = 3'd1,
		REG_DEBOUNCE     = 3'd2,
		REG_RAMP_DIV     = 3'd3,
		REG_DUTY_MAX     = 3'd4,
		REG_BLINK_ON     = 3'd5,
		REG_BLINK_OFF    = 3'd6
	} cfg_reg_t;

	typedef struct packed {
		logic             light_on;
		logic [DutyW-1:0] duty;
		logic             blink_mode;
		logic             ramp_down;
	} result_t;

endpackage

// File: src/button_press_classifier_dimmer_top.sv
// Top level of the button press classifier and dimmer: gesture logic, ramp, blinker, result queue.
//
//  channel | handshake             | payload
//  --------+-----------------------+--------------------------------------------
//  in      | in_valid / in_ready   | button_down, tick
//  out     | out_valid / out_ready | light_on, duty, blink_mode, ramp_down
//  cfg     | cfg_wen               | cfg_idx, cfg_wdata
//
// One item is accepted per cycle while the queue has room; its state update and result are computed in that cycle.
// The result is registered into the result queue on acceptance.
// A two-entry result queue lets one more item in while a result waits to be taken.
// Input stalls only when both queue entries are full.
// Reset is asynchronous and active low and sets all registers but the result queue storage to their power-on values.
module button_press_classifier_dimmer_top
	import bpcd_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                button_down,
	input  logic                tick,
	output logic                out_valid,
	input  logic                out_ready,
	output logic                light_on,
	output logic [DutyW-1:0]    duty,
	output logic                blink_mode,
	output logic                ramp_down,
	input  logic                cfg_wen,
	input  logic [CfgIdxW-1:0]  cfg_idx,
	input  logic [CfgDataW-1:0] cfg_wdata
);

	logic [ElapsedW-1:0] long_press_q, double_press_q, debounce_q;
	logic [DivW-1:0]     ramp_div_q;
	logic [DutyW-1:0]    duty_max_q;
	logic [BlinkW-1:0]   blink_on_q, blink_off_q;

	logic [ElapsedW-1:0] press_elapsed_q, press_elapsed_d;
	logic                press_active_q, press_active_d;
	logic [1:0]          press_count_q, press_count_d;
	logic                debounce_armed_q, debounce_armed_d;
	logic                ramp_dir_q, ramp_dir_d;
	logic [DutyW-1:0]    duty_level_q, duty_level_d;
	logic [DivW-1:0]     ramp_polls_q, ramp_polls_d;
	logic                gate_on_q, gate_on_d;
	logic                blink_active_q, blink_active_d;
	logic                blink_off_phase_q, blink_off_phase_d;
	logic [BlinkW-1:0]   blink_ticks_q, blink_ticks_d;

	result_t             res_d;
	result_t             queue_q [2];
	logic                wr_ptr_q, rd_ptr_q;
	logic [1:0]          count_q;
	logic                in_fire, out_fire;
	logic [DivW:0]       polls_next;

	assign in_ready  = (count_q != 2'd2);
	assign out_valid = (count_q != 2'd0);
	assign in_fire   = in_valid && in_ready;
	assign out_fire  = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			long_press_q   <= LongPressRst;
			double_press_q <= DoublePressRst;
			debounce_q     <= DebounceRst;
			ramp_div_q     <= RampDivRst;
			duty_max_q     <= DutyMaxRst;
			blink_on_q     <= BlinkOnRst;
			blink_off_q    <= BlinkOffRst;
		end else if (cfg_wen) begin
			case (cfg_idx)
				REG_LONG_PRESS:   long_press_q   <= cfg_wdata[ElapsedW-1:0];
				REG_DOUBLE_PRESS: double_press_q <= cfg_wdata[ElapsedW-1:0];
				REG_DEBOUNCE:     debounce_q     <= cfg_wdata[ElapsedW-1:0];
				REG_RAMP_DIV:     ramp_div_q     <= cfg_wdata[DivW-1:0];
				REG_DUTY_MAX:     duty_max_q     <= cfg_wdata[DutyW-1:0];
				REG_BLINK_ON:     blink_on_q     <= cfg_wdata[BlinkW-1:0];
				REG_BLINK_OFF:    blink_off_q    <= cfg_wdata[BlinkW-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		press_elapsed_d   = press_elapsed_q;
		press_active_d    = press_active_q;
		press_count_d     = press_count_q;
		debounce_armed_d  = debounce_armed_q;
		ramp_dir_d        = ramp_dir_q;
		duty_level_d      = duty_level_q;
		ramp_polls_d      = ramp_polls_q;
		gate_on_d         = gate_on_q;
		blink_active_d    = blink_active_q;
		blink_off_phase_d = blink_off_phase_q;
		blink_ticks_d     = blink_ticks_q;
		polls_next        = {1'b0, ramp_polls_q} + 1'b1;

		if (tick) begin
			if (press_active_q && press_elapsed_q < ElapsedMax) begin
				press_elapsed_d = press_elapsed_q + 1'b1;
			end
			blink_ticks_d = blink_ticks_q + 1'b1;
		end

		if (button_down) begin
			if (!press_active_q) begin
				press_active_d  = 1'b1;
				press_elapsed_d = '0;
			end
			debounce_armed_d = 1'b1;
			if (press_elapsed_d >= long_press_q) begin
				if (polls_next > {1'b0, ramp_div_q}) begin
					ramp_polls_d = '0;
					if (!ramp_dir_q) begin
						duty_level_d = (duty_level_q < duty_max_q) ?
							duty_level_q + 1'b1 : duty_max_q;
					end else if (duty_level_q != '0) begin
						duty_level_d = duty_level_q - 1'b1;
					end
				end else begin
					ramp_polls_d = polls_next[DivW-1:0];
				end
			end
		end else if (press_active_q) begin
			if (press_elapsed_d >= long_press_q) begin
				press_active_d = 1'b0;
				ramp_dir_d     = !ramp_dir_q;
			end else if (press_elapsed_d >= debounce_q) begin
				if (press_elapsed_d >= double_press_q) begin
					press_active_d = 1'b0;
					press_count_d  = '0;
					gate_on_d      = blink_active_q ? 1'b0 : !gate_on_q;
					blink_active_d = 1'b0;
				end else if (debounce_armed_q) begin
					press_count_d    = press_count_q + 1'b1;
					debounce_armed_d = 1'b0;
				end
			end
			if (press_count_d >= PressCountDouble) begin
				press_active_d = 1'b0;
				press_count_d  = '0;
				blink_active_d = 1'b1;
			end
		end

		// The off phase may end and hand over to the on phase within one item.
		if (blink_active_d) begin
			if (blink_off_phase_d) begin
				if (blink_ticks_d <= blink_off_q) begin
					gate_on_d = 1'b0;
				end else begin
					blink_off_phase_d = 1'b0;
					blink_ticks_d     = '0;
				end
			end
			if (!blink_off_phase_d) begin
				if (blink_ticks_d <= blink_on_q) begin
					gate_on_d = 1'b1;
				end else begin
					blink_off_phase_d = 1'b1;
					blink_ticks_d     = '0;
				end
			end
		end

		res_d.light_on   = gate_on_d;
		res_d.duty       = (duty_level_d < duty_max_q) ? duty_level_d : duty_max_q;
		res_d.blink_mode = blink_active_d;
		res_d.ramp_down  = ramp_dir_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			press_elapsed_q   <= '0;
			press_active_q    <= 1'b0;
			press_count_q     <= '0;
			debounce_armed_q  <= 1'b0;
			ramp_dir_q        <= 1'b0;
			duty_level_q      <= DutyLevelRst;
			ramp_polls_q      <= '0;
			gate_on_q         <= 1'b0;
			blink_active_q    <= 1'b0;
			blink_off_phase_q <= 1'b1;
			blink_ticks_q     <= '0;
		end else if (in_fire) begin
			press_elapsed_q   <= press_elapsed_d;
			press_active_q    <= press_active_d;
			press_count_q     <= press_count_d;
			debounce_armed_q  <= debounce_armed_d;
			ramp_dir_q        <= ramp_dir_d;
			duty_level_q      <= duty_level_d;
			ramp_polls_q      <= ramp_polls_d;
			gate_on_q         <= gate_on_d;
			blink_active_q    <= blink_active_d;
			blink_off_phase_q <= blink_off_phase_d;
			blink_ticks_q     <= blink_ticks_d;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			queue_q[wr_ptr_q] <= res_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= '0;
		end else begin
			if (in_fire) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (out_fire) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({in_fire, out_fire})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	assign light_on   = queue_q[rd_ptr_q].light_on;
	assign duty       = queue_q[rd_ptr_q].duty;
	assign blink_mode = queue_q[rd_ptr_q].blink_mode;
	assign ramp_down  = queue_q[rd_ptr_q].ramp_down;

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != 2'd3)
		else $error("result queue count out of range");

	a_ptr_count: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == 2'd0 || count_q == 2'd2) |-> (wr_ptr_q == rd_ptr_q))
		else $error("queue pointers disagree with count");

	a_press_count: assert property (@(posedge clk) disable iff (!arst_n)
		press_count_q < PressCountDouble)
		else $error("press count reached a double press without resolving");

	a_dir_flip: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(ramp_dir_q) |-> $past(press_active_q) && $past(!button_down))
		else $error("ramp direction changed outside a long release");

	a_blink_gate: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(blink_active_q) |-> (press_count_q == 2'd0) && !press_active_q)
		else $error("blink mode entered with a press sequence still open");

endmodule

// File: bench/button_press_classifier_dimmer_top_test.sv
// Self-checking testbench for the button press classifier and dimmer, driven by random button polls.
module button_press_classifier_dimmer_top_test;
	timeunit 1ns;
	timeprecision 1ps;
	import bpcd_pkg::*;

	localparam int RandomPolls = 1650;
	localparam int StallLimit  = 2000;
	localparam int SpanCap     = 300;
	localparam int RampCap     = 600;

	typedef struct packed {
		logic down;
		logic tk;
	} poll_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_ready;
	logic                button_down = 1'b0;
	logic                tick = 1'b0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	logic                light_on;
	logic [DutyW-1:0]    duty;
	logic                blink_mode;
	logic                ramp_down;
	logic                cfg_wen = 1'b0;
	logic [CfgIdxW-1:0]  cfg_idx = '0;
	logic [CfgDataW-1:0] cfg_wdata = '0;

	// Predicted state of the light channel.
	logic [ElapsedW-1:0] held_ms;
	logic                in_press;
	logic [1:0]          clicks;
	logic                click_armed;
	logic                dimming;
	logic [DutyW-1:0]    level;
	logic [DivW-1:0]     ramp_count;
	logic                gate;
	logic                blinking;
	logic                blink_dark;
	logic [BlinkW-1:0]   blink_count;

	// Predicted register contents.
	logic [ElapsedW-1:0] long_ms;
	logic [ElapsedW-1:0] double_ms;
	logic [ElapsedW-1:0] debounce_ms;
	logic [DivW-1:0]     ramp_div;
	logic [DutyW-1:0]    duty_cap;
	logic [BlinkW-1:0]   on_ms;
	logic [BlinkW-1:0]   off_ms;

	poll_t   polls_q[$];
	result_t lights_q[$];
	int      queued = 0;
	int      tick_pct = 100;
	int      errors = 0;
	int      results_seen = 0;

	logic    offer;
	poll_t   next_poll;
	int      burst_left;
	int      gap_left;

	result_t want;
	logic    ready_next;
	int      hold_left;
	int      rcv_mode;
	int      rcv_cycle;

	button_press_classifier_dimmer_top u_dut (.*);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic result_t next_light(input logic down, input logic tk);
		logic [DivW:0] polls_next;
		result_t r;
		if (tk) begin
			if (in_press && held_ms != ElapsedMax) begin
				held_ms++;
			end
			blink_count++;
		end
		if (down) begin
			if (!in_press) begin
				in_press = 1'b1;
				held_ms = '0;
			end
			click_armed = 1'b1;
			if (held_ms >= long_ms) begin
				polls_next = {1'b0, ramp_count} + 1'b1;
				if (polls_next > {1'b0, ramp_div}) begin
					ramp_count = '0;
					if (!dimming) begin
						level = (level < duty_cap) ? level + 1'b1 : duty_cap;
					end else if (level != '0) begin
						level--;
					end
				end else begin
					ramp_count = polls_next[DivW-1:0];
				end
			end
		end else if (in_press) begin
			if (held_ms >= long_ms) begin
				in_press = 1'b0;
				dimming = !dimming;
			end else if (held_ms >= debounce_ms) begin
				if (held_ms >= double_ms) begin
					in_press = 1'b0;
					clicks = '0;
					gate = blinking ? 1'b0 : !gate;
					blinking = 1'b0;
				end else if (click_armed) begin
					clicks++;
					click_armed = 1'b0;
				end
			end
			if (clicks >= PressCountDouble) begin
				in_press = 1'b0;
				clicks = '0;
				blinking = 1'b1;
			end
		end
		if (blinking) begin
			if (blink_dark) begin
				if (blink_count <= off_ms) begin
					gate = 1'b0;
				end else begin
					blink_dark = 1'b0;
					blink_count = '0;
				end
			end
			if (!blink_dark) begin
				if (blink_count <= on_ms) begin
					gate = 1'b1;
				end else begin
					blink_dark = 1'b1;
					blink_count = '0;
				end
			end
		end
		r.light_on = gate;
		r.duty = (level < duty_cap) ? level : duty_cap;
		r.blink_mode = blinking;
		r.ramp_down = dimming;
		return r;
	endfunction

	task automatic report_mismatch(input string msg);
		if (errors < 100) begin
			$display("%0t ns: result %0d: %s", $time, results_seen, msg);
		end
		errors++;
	endtask

	task automatic add_one(input logic down, input logic tk);
		poll_t p;
		p.down = down;
		p.tk = tk;
		polls_q.push_back(p);
		queued++;
	endtask

	task automatic add_polls(input logic down, input int n);
		for (int i = 0; i < n; i++) begin
			add_one(down, $urandom_range(1, 100) <= tick_pct);
		end
	endtask

	// Polls needed to see about ms ticks at the current tick rate, with some jitter.
	function automatic int span(input int ms);
		int t;
		t = ms * 100 / tick_pct + $urandom_range(0, 4) - 2;
		if (t < 1) begin
			t = 1;
		end
		return (t > SpanCap) ? SpanCap : t;
	endfunction

	function automatic logic [CfgDataW-1:0] with_junk(input int value, input int width);
		logic [31:0] v;
		v = value;
		if ($urandom_range(0, 3) == 0) begin
			v = v | ($urandom << width);
		end
		return v[CfgDataW-1:0];
	endfunction

	task automatic write_reg(input cfg_reg_t r, input logic [CfgDataW-1:0] v);
		cfg_wen <= 1'b1;
		cfg_idx <= r;
		cfg_wdata <= v;
		case (r)
			REG_LONG_PRESS:   long_ms = v[ElapsedW-1:0];
			REG_DOUBLE_PRESS: double_ms = v[ElapsedW-1:0];
			REG_DEBOUNCE:     debounce_ms = v[ElapsedW-1:0];
			REG_RAMP_DIV:     ramp_div = v[DivW-1:0];
			REG_DUTY_MAX:     duty_cap = v[DutyW-1:0];
			REG_BLINK_ON:     on_ms = v[BlinkW-1:0];
			REG_BLINK_OFF:    off_ms = v[BlinkW-1:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic set_config(input int lp, input int dp, input int db, input int dv,
			input int dm, input int on, input int off);
		write_reg(REG_LONG_PRESS, with_junk(lp, ElapsedW));
		write_reg(REG_DOUBLE_PRESS, with_junk(dp, ElapsedW));
		write_reg(REG_DEBOUNCE, with_junk(db, ElapsedW));
		write_reg(REG_RAMP_DIV, with_junk(dv, DivW));
		write_reg(REG_DUTY_MAX, with_junk(dm, DutyW));
		write_reg(REG_BLINK_ON, CfgDataW'(on));
		write_reg(REG_BLINK_OFF, CfgDataW'(off));
		cfg_wen <= 1'b0;
	endtask

	task automatic wait_idle();
		@(posedge clk);
		while (polls_q.size() != 0 || in_valid || lights_q.size() != 0) begin
			@(posedge clk);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			burst_left = 1;
			gap_left = 0;
		end else begin
			offer = in_valid;
			if (in_valid && in_ready) begin
				lights_q.push_back(next_light(button_down, tick));
				offer = 1'b0;
			end
			if (!offer) begin
				if (gap_left != 0) begin
					gap_left--;
				end else if (polls_q.size() != 0) begin
					next_poll = polls_q.pop_front();
					button_down <= next_poll.down;
					tick <= next_poll.tk;
					offer = 1'b1;
					burst_left--;
					if (burst_left <= 0) begin
						burst_left = $urandom_range(1, 40);
						case ($urandom_range(0, 3))
							0: gap_left = 0;
							1: gap_left = $urandom_range(1, 3);
							2: gap_left = $urandom_range(1, 8);
							default: gap_left = $urandom_range(10, 20);
						endcase
					end
				end
			end
			in_valid <= offer;
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			hold_left = 0;
			rcv_mode = 0;
			rcv_cycle = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (lights_q.size() == 0) begin
					report_mismatch("result arrived with nothing expected");
				end else begin
					want = lights_q.pop_front();
					if (light_on !== want.light_on) begin
						report_mismatch($sformatf("light_on %0b, expected %0b",
							light_on, want.light_on));
					end
					if (duty !== want.duty) begin
						report_mismatch($sformatf("duty %0d, expected %0d", duty, want.duty));
					end
					if (blink_mode !== want.blink_mode) begin
						report_mismatch($sformatf("blink_mode %0b, expected %0b",
							blink_mode, want.blink_mode));
					end
					if (ramp_down !== want.ramp_down) begin
						report_mismatch($sformatf("ramp_down %0b, expected %0b",
							ramp_down, want.ramp_down));
					end
				end
				results_seen++;
				// Now and then hold off long enough for the block to fill and stall its input.
				if (results_seen % 500 == 250) begin
					hold_left = $urandom_range(40, 70);
				end
			end
			rcv_cycle++;
			if (rcv_cycle % 64 == 0) begin
				rcv_mode = $urandom_range(0, 3);
			end
			if (hold_left != 0) begin
				hold_left--;
				ready_next = 1'b0;
			end else begin
				case (rcv_mode)
					0: ready_next = 1'b1;
					1: ready_next = 1'($urandom_range(0, 1));
					2: ready_next = ($urandom_range(0, 3) != 0);
					default: ready_next = rcv_cycle[0];
				endcase
			end
			out_ready <= ready_next;
		end
	end

	initial begin
		int stalled;
		stalled = 0;
		wait (arst_n);
		while (stalled < StallLimit) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_wen) begin
				stalled = 0;
			end else begin
				stalled++;
			end
		end
		$display("TB_ERROR");
		$finish;
	end

	initial begin
		int first;
		int phase;
		int phase_end;
		int n;
		held_ms = '0;
		in_press = 1'b0;
		clicks = '0;
		click_armed = 1'b0;
		dimming = 1'b0;
		level = DutyLevelRst;
		ramp_count = '0;
		gate = 1'b0;
		blinking = 1'b0;
		blink_dark = 1'b1;
		blink_count = '0;
		long_ms = LongPressRst;
		double_ms = DoublePressRst;
		debounce_ms = DebounceRst;
		ramp_div = RampDivRst;
		duty_cap = DutyMaxRst;
		on_ms = BlinkOnRst;
		off_ms = BlinkOffRst;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// A release with no press going on, then a press left open across the register writes.
		add_one(1'b0, 1'b1);
		add_one(1'b1, 1'b0);
		add_one(1'b1, 1'b1);
		add_one(1'b0, 1'b0);
		wait_idle();

		set_config(8, 5, 1, 0, 1023, 2, 3);
		add_polls(1'b1, 3);
		add_polls(1'b0, 3);
		add_polls(1'b1, 2);
		add_polls(1'b0, 1);
		add_polls(1'b1, 1);
		add_polls(1'b0, 4);
		add_polls(1'b1, 3);
		add_polls(1'b0, 3);
		add_polls(1'b1, 10);
		add_polls(1'b0, 1);
		wait_idle();

		first = queued;
		phase = 0;
		while (queued - first < RandomPolls) begin
			case (phase)
				0: set_config(1, 1, 0, 0, 1, 0, 0);
				1: set_config(2047, 2047, 2047, 255, 1023, 65535, 65535);
				2: set_config(2047, 30, 0, 255, 0, 65535, 0);
				3: set_config(0, 0, 0, 255, 1023, 0, 65535);
				default: set_config($urandom_range(0, 40), $urandom_range(0, 30),
					$urandom_range(0, 6),
					($urandom_range(0, 7) == 0) ? 255 : $urandom_range(0, 4),
					($urandom_range(0, 1) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, 40),
					$urandom_range(0, 8), $urandom_range(0, 8));
			endcase
			tick_pct = $urandom_range(55, 100);
			phase_end = queued + $urandom_range(60, 200);
			while (queued < phase_end && queued - first < RandomPolls) begin
				case ($urandom_range(0, 9))
					0: begin
						n = $urandom_range(1, 12);
						repeat (n) add_one(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
					end
					1, 2, 3: begin
						add_polls(1'b1, span($urandom_range(debounce_ms, double_ms)));
						add_polls(1'b0, span(double_ms) + $urandom_range(1, 20));
					end
					4, 5, 6: begin
						add_polls(1'b1, span(debounce_ms));
						add_polls(1'b0, $urandom_range(1, 2));
						add_polls(1'b1, $urandom_range(1, 2));
						add_polls(1'b0, $urandom_range(1, 2));
						add_polls(1'b0, $urandom_range(1, 30));
					end
					7, 8: begin
						n = span(long_ms) + $urandom_range(0, 3 * (ramp_div + 1));
						add_polls(1'b1, (n > RampCap) ? RampCap : n);
						add_polls(1'b0, $urandom_range(1, 5));
					end
					default: begin
						repeat ($urandom_range(1, 4)) begin
							add_polls(1'($urandom_range(0, 1)),
								$urandom_range(1, span(double_ms) + 2));
						end
					end
				endcase
			end
			wait_idle();
			phase++;
		end

		repeat (4) @(posedge clk);
		if (errors == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

// File: files.f
src/bpcd_pkg.sv
src/button_press_classifier_dimmer_top.sv
bench/button_press_classifier_dimmer_top_test.sv
